// ===== rtl/core/v_disparity_row_histogram_macros.svh =====
// assertion macros for the v-disparity row histogram checker
// no dependencies
`ifndef V_DISPARITY_ROW_HISTOGRAM_MACROS_SVH
`define V_DISPARITY_ROW_HISTOGRAM_MACROS_SVH

// same-cycle implication, reset gated
`define VDRH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset gated
`define VDRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vdrh_pkg.sv =====
// shared types, register indexes and bin rounding for the v-disparity row histogram
// no dependencies
package vdrh_pkg;

  localparam int unsigned CountW = 12;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned ScaleW = 24;

  typedef logic [CountW-1:0] count_t;

  localparam logic RegTopBin     = 1'b0;
  localparam logic RegLevelScale = 1'b1;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  // round raw/16 to nearest, ties to even
  function automatic count_t round_bin(input logic [14:0] raw);
    logic [10:0] q;
    logic [3:0]  r;
    logic        up;
    q  = raw[14:4];
    r  = raw[3:0];
    up = (r > 4'd8) || ((r == 4'd8) && q[0]);
    return {1'b0, q} + {11'd0, up};
  endfunction

endpackage

// ===== rtl/core/v_disparity_row_histogram.sv =====
// v-disparity row histogram top level: pixel binning, counter chain, readout
// depends on vdrh_pkg and vdrh_cell
// While a row streams in, the block takes one pixel per clock: each pixel with
// positive disparity is binned and the matching cell of the counter chain
// increments in that cycle. The pixel that carries end_of_row is counted, then
// input ready drops and the chain shifts toward its head one bin per cycle,
// giving top_bin+1 results (top_bin limited to BINS-1) at one per cycle when
// the output is not stalled, from the single output port at the chain head.
// All counters are zero when ready rises.
module v_disparity_row_histogram #(
  parameter int unsigned BINS    = 64,
  parameter int unsigned MAX_ROW = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] disparity_raw_i,
  input  logic               end_of_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         bin_index_o,
  output logic [11:0]        bin_count_o,
  output logic [7:0]         bin_level_o,
  output logic               last_bin_o
);

  localparam logic [11:0] CountMax = (MAX_ROW < 4095) ? 12'(MAX_ROW) : 12'd4095;
  localparam logic [5:0]  TopMax   = 6'(BINS - 1);

  logic [5:0]  top_bin_q;
  logic [23:0] level_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_bin_q     <= 6'd63;
      level_scale_q <= 24'd16320;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vdrh_pkg::RegTopBin:     top_bin_q     <= cfg_data_i[5:0];
        vdrh_pkg::RegLevelScale: level_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [5:0] top_eff;
  assign top_eff = (top_bin_q > TopMax) ? TopMax : top_bin_q;

  vdrh_pkg::state_e state_q, state_d;
  logic             rd_active;
  logic             in_acc;
  logic             advance;
  logic             last_now;
  logic [5:0]       idx_q;

  assign in_acc   = in_valid_i && in_ready_o;
  assign advance  = !out_valid_o || out_ready_i;
  assign last_now = (idx_q == top_eff);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vdrh_pkg::StIdle: if (in_acc && end_of_row_i) state_d = vdrh_pkg::StRead;
      vdrh_pkg::StRead: if (advance && last_now) state_d = vdrh_pkg::StIdle;
      default:          state_d = vdrh_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    rd_active  = 1'b0;
    unique case (state_q)
      vdrh_pkg::StIdle: in_ready_o = 1'b1;
      vdrh_pkg::StRead: rd_active  = 1'b1;
      default:          in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vdrh_pkg::StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (!rd_active) begin
        idx_q <= '0;
      end else if (advance) begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  // pixel binning
  logic             pix_ok;
  vdrh_pkg::count_t bin_raw;
  vdrh_pkg::count_t bin_sel;

  assign pix_ok  = !disparity_raw_i[15] && (disparity_raw_i != 16'sd0);
  assign bin_raw = vdrh_pkg::round_bin(disparity_raw_i[14:0]);
  assign bin_sel = (bin_raw > {6'd0, top_eff}) ? {6'd0, top_eff} : bin_raw;

  vdrh_pkg::cell_ctrl_t ctrl;
  assign ctrl.shift = rd_active && advance && !last_now;
  assign ctrl.clear = rd_active && advance && last_now;

  vdrh_pkg::count_t cnt [BINS];

  for (genvar i = 0; i < BINS; i++) begin : g_cell
    localparam logic [11:0] CellIdx = 12'(i);
    logic             hit;
    vdrh_pkg::count_t nxt;
    assign hit = in_acc && pix_ok && (bin_sel == CellIdx);
    if (i == BINS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_link
      assign nxt = cnt[i+1];
    end
    vdrh_cell #(
      .CountMax (CountMax)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .hit_i   (hit),
      .count_i (nxt),
      .count_o (cnt[i])
    );
  end

  // level from the chain head
  logic [35:0] prod;
  logic [19:0] scaled;
  logic [7:0]  level;
  assign prod   = {24'd0, cnt[0]} * {12'd0, level_scale_q};
  assign scaled = prod[35:16];
  assign level  = (|scaled[19:8]) ? 8'd255 : scaled[7:0];

  logic        out_valid_q;
  logic        load;
  logic [5:0]  idx_out_q;
  logic [11:0] count_out_q;
  logic [7:0]  level_out_q;
  logic        last_out_q;

  assign load = rd_active && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_out_q   <= idx_q;
      count_out_q <= cnt[0];
      level_out_q <= level;
      last_out_q  <= last_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = idx_out_q;
  assign bin_count_o = count_out_q;
  assign bin_level_o = level_out_q;
  assign last_bin_o  = last_out_q;

endmodule

// ===== rtl/core/vdrh_cell.sv =====
// one saturating bin counter of the histogram chain
// depends on vdrh_pkg
module vdrh_cell #(
  parameter logic [11:0] CountMax = 12'd2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vdrh_pkg::cell_ctrl_t ctrl_i,
  input  logic                 hit_i,
  input  vdrh_pkg::count_t     count_i,
  output vdrh_pkg::count_t     count_o
);

  vdrh_pkg::count_t count_q, count_d;

  always_comb begin
    count_d = count_q;
    priority if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.shift) begin
      count_d = count_i;
    end else if (hit_i && (count_q < CountMax)) begin
      count_d = count_q + 12'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== rtl/core/vdrh_checker.sv =====
// port-level checks for the v-disparity row histogram, bound to the top level
// depends on v_disparity_row_histogram_macros.svh
`include "v_disparity_row_histogram_macros.svh"

module vdrh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        end_of_row_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  bin_index_o,
  input logic [11:0] bin_count_o,
  input logic [7:0]  bin_level_o,
  input logic        last_bin_o
);

  `VDRH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(bin_index_o) && $stable(bin_count_o) && $stable(last_bin_o),
    "stalled result changed")
  `VDRH_ASSERT_NEXT(a_row_end_readout, clk_i, rst_ni,
    in_valid_i && in_ready_o && end_of_row_i, !in_ready_o,
    "input still ready after row end")
  `VDRH_ASSERT_IMPL(a_zero_level, clk_i, rst_ni, out_valid_o && (bin_count_o == 12'd0),
    bin_level_o == 8'd0, "nonzero level for empty bin")
  `VDRH_ASSERT_IMPL(a_first_bin, clk_i, rst_ni, $rose(out_valid_o),
    bin_index_o == 6'd0, "readout did not start at bin zero")

endmodule

bind v_disparity_row_histogram vdrh_checker u_vdrh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .end_of_row_i (end_of_row_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .bin_index_o  (bin_index_o),
  .bin_count_o  (bin_count_o),
  .bin_level_o  (bin_level_o),
  .last_bin_o   (last_bin_o)
);
